@@ rtl/hks_pkg.sv @@
// Package for the histogram k-th select block: field widths, codes and
// default sizes. No dependencies.
package hks_pkg;

  localparam int VALUE_W  = 10;
  localparam int RANK_W   = 16;
  localparam int CNT_W    = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int DEF_NUM_VALUES = 1024;
  localparam int DEF_BLOCK_SIZE = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANK      = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_QBLK,
    ST_QVAL,
    ST_DONE
  } state_t;

endpackage

@@ rtl/histogram_kth_select.sv @@
// Order-statistic selection over a multiset kept as a count histogram in one
// memory and per-block count sums in a second memory. Depends on hks_pkg.
//
// Sequencing: insert and remove pass through block index, memory read, write
// back and output stage; a query walks over block sums and then over counts,
// one memory read per cycle; a rejected query or an unused op goes straight to
// the output stage. One item is worked on at a time; the next is taken in the
// cycle after the result has moved into the output register. Reset (rst,
// synchronous) starts a clearing pass that zeroes both memories; no input is
// taken then.
module histogram_kth_select
  import hks_pkg::*;
#(
  parameter int NUM_VALUES = DEF_NUM_VALUES,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [9:0] value, [25:10] rank_k, [31:26] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [9:0] selected_value, [11:10] status, [15:12] zero
);

  localparam int NUM_BLOCKS = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int VAL_W = $clog2(NUM_VALUES);
  localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int BS_W  = CNT_W + $clog2(BLOCK_SIZE);
  localparam int TOT_W = CNT_W + VAL_W;
  // The block index is found by multiplying with a rounded-up reciprocal of
  // BLOCK_SIZE; this shift keeps it exact for every index below NUM_VALUES.
  localparam int BLK_SHIFT = VAL_W + $clog2(BLOCK_SIZE);
  localparam int RCP_W     = VAL_W + 2;
  localparam int QP_W      = VAL_W + RCP_W;
  localparam logic [RCP_W-1:0] BLK_RECIP =
    RCP_W'(((64'd1 << BLK_SHIFT) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));

  localparam logic [VAL_W-1:0] LAST_IDX = VAL_W'(NUM_VALUES - 1);
  localparam logic [VAL_W:0]   NB_LIM   = (VAL_W + 1)'(NUM_BLOCKS);
  localparam logic [VAL_W-1:0] BLK_STEP = VAL_W'(BLOCK_SIZE);

  // Reduce a value index modulo NUM_VALUES by conditional subtraction of
  // shifted copies; a 10-bit field needs at most eight steps.
  function automatic logic [VAL_W-1:0] reduce_value(input logic [VALUE_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int i = 7; i >= 0; i--) begin
      if (r >= (32'(NUM_VALUES) << i)) begin
        r = r - (32'(NUM_VALUES) << i);
      end
    end
    return VAL_W'(r);
  endfunction

  // Input fields.
  logic [VALUE_W-1:0] in_value;
  logic [RANK_W-1:0]  in_rank;
  op_t                in_op;
  assign in_value = s_tdata[9:0];
  assign in_rank  = s_tdata[25:10];
  assign in_op    = op_t'(s_tuser);

  // Control and datapath registers.
  state_t             state, state_next;
  logic [VAL_W-1:0]   clr_idx;
  op_t                op_r;
  logic [TOT_W-1:0]   rank_r;
  logic [VAL_W-1:0]   vptr;
  logic [BLK_W-1:0]   quot;
  logic [BLK_W-1:0]   bidx;
  logic [TOT_W-1:0]   run;
  logic [TOT_W-1:0]   total_count;
  logic [VALUE_W-1:0] res_value;
  status_t            res_status;

  // Count histogram memory: one write port, one registered read port.
  logic [CNT_W-1:0] cnt_mem [NUM_VALUES];
  logic             cnt_we;
  logic [VAL_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

  // Block sum memory.
  logic [BS_W-1:0]  blk_mem [NUM_BLOCKS];
  logic             blk_we;
  logic [BLK_W-1:0] blk_waddr, blk_raddr;
  logic [BS_W-1:0]  blk_wdata, blk_rdata;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata <= blk_mem[blk_raddr];
  end

  // Decisions shared by the state machine and the datapath.
  logic             accept;
  logic             out_free;
  logic             rank_bad;
  logic             blk_hit;
  logic             val_hit;
  logic             upd_ok;
  logic [TOT_W-1:0] blk_run, val_run;
  logic [QP_W-1:0]  quot_prod;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  // A query asks for a rank that the stored multiset does not have.
  assign rank_bad  = (in_rank == '0) || (TOT_W'(in_rank) > total_count);
  assign quot_prod = QP_W'(vptr) * QP_W'(BLK_RECIP);
  assign blk_run   = run + TOT_W'(blk_rdata);
  assign val_run   = run + TOT_W'(cnt_rdata);
  assign blk_hit   = (blk_run >= rank_r);
  assign val_hit   = (val_run >= rank_r);
  // An insert succeeds below the count ceiling, a remove above zero.
  assign upd_ok    = (op_r == OP_INSERT) ? (cnt_rdata != COUNT_MAX) : (cnt_rdata != '0);

  assign s_tready = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT, OP_REMOVE: state_next = ST_DIV;
            OP_QUERY:             state_next = rank_bad ? ST_DONE : ST_QBLK;
            OP_UNUSED:            state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV:    state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_QBLK: begin
        if (blk_hit) state_next = ST_QVAL;
      end
      ST_QVAL: begin
        if (val_hit) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Memory addresses and writes.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = vptr;
    cnt_wdata = '0;
    cnt_raddr = vptr;
    blk_we    = 1'b0;
    blk_waddr = quot;
    blk_wdata = '0;
    blk_raddr = quot;
    unique case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        blk_we    = ({1'b0, clr_idx} < NB_LIM);
        blk_waddr = clr_idx[BLK_W-1:0];
      end
      ST_IDLE: begin
        // The first block sum is fetched as a query is taken.
        blk_raddr = '0;
      end
      ST_UPDATE: begin
        cnt_we = upd_ok;
        blk_we = upd_ok;
        if (op_r == OP_INSERT) begin
          cnt_wdata = cnt_rdata + 1'b1;
          blk_wdata = blk_rdata + 1'b1;
        end else begin
          cnt_wdata = cnt_rdata - 1'b1;
          blk_wdata = blk_rdata - 1'b1;
        end
      end
      ST_QBLK: begin
        // On a hit vptr already holds the block's first value.
        blk_raddr = bidx + 1'b1;
        cnt_raddr = vptr;
      end
      ST_QVAL: begin
        cnt_raddr = vptr + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      total_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_UPDATE && upd_ok) begin
        if (op_r == OP_INSERT) begin
          total_count <= total_count + 1'b1;
        end else begin
          total_count <= total_count - 1'b1;
        end
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r       <= in_op;
          rank_r     <= TOT_W'(in_rank);
          vptr       <= (in_op == OP_QUERY) ? '0 : reduce_value(in_value);
          quot       <= '0;
          bidx       <= '0;
          run        <= '0;
          res_value  <= '0;
          res_status <= (in_op == OP_QUERY && rank_bad) ? STATUS_RANK : STATUS_OK;
        end
      end
      ST_DIV: begin
        // Block index of the value, taken from the reciprocal product.
        quot <= BLK_W'(quot_prod >> BLK_SHIFT);
      end
      ST_UPDATE: begin
        if (!upd_ok) begin
          res_status <= (op_r == OP_INSERT) ? STATUS_SATURATED : STATUS_UNDERFLOW;
        end
      end
      ST_QBLK: begin
        if (!blk_hit) begin
          run  <= blk_run;
          bidx <= bidx + 1'b1;
          vptr <= vptr + BLK_STEP;
        end
      end
      ST_QVAL: begin
        if (val_hit) begin
          res_value <= VALUE_W'(vptr);
        end else begin
          run  <= val_run;
          vptr <= vptr + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {4'b0000, res_status, res_value};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for histogram_kth_select: directed table and random
// traffic, scored against answers given in the table or an in-bench histogram model.
// Depends on hks_pkg and the histogram_kth_select RTL.
module testbench
  import hks_pkg::*;
();

  localparam int NUM_VALUES     = DEF_NUM_VALUES;
  localparam int BLOCK_SIZE     = DEF_BLOCK_SIZE;
  localparam int NUM_BLOCKS     = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int RANDOM_ITEMS   = 600;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = NUM_BLOCKS + BLOCK_SIZE + 8;
  localparam int NUM_DIRECTED   = 25;

  typedef struct packed {
    logic [VALUE_W-1:0] sel;
    status_t            status;
  } kth_result_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    bit                 typed;   // expected answer given in the row
    kth_result_t        res;
  } stim_row_t;

  localparam kth_result_t FROM_MODEL = '{sel: '0, status: STATUS_OK};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [9:0] value, [25:10] rank_k, [31:26] zero
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [9:0] selected_value, [11:10] status, [15:12] zero

  // Histogram model state.
  logic [CNT_W-1:0] hist_count [NUM_VALUES];
  logic [20:0]      blk_total  [NUM_BLOCKS];
  logic [25:0]      stored_total;

  kth_result_t  answers_due [$];
  int unsigned  answers_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  bit           held_off = 1'b0;
  stim_row_t    directed_rows [NUM_DIRECTED];

  histogram_kth_select DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    end
  endtask

  // Walk block sums until the running count reaches k, then the counts inside
  // that block.
  function automatic logic [VALUE_W-1:0] locate_rank(input logic [RANK_W-1:0] k);
    longint run;
    int     lo_val;
    int     hi_val;
    run = 0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (run + blk_total[b] >= k) begin
        lo_val = b * BLOCK_SIZE;
        hi_val = lo_val + BLOCK_SIZE;
        if (hi_val > NUM_VALUES) begin
          hi_val = NUM_VALUES;
        end
        for (int v = lo_val; v < hi_val; v++) begin
          run += hist_count[v];
          if (run >= k) begin
            return VALUE_W'(v);
          end
        end
        return '0;
      end
      run += blk_total[b];
    end
    return '0;
  endfunction

  // Apply one accepted item to the histogram and work out its answer.
  task automatic histogram_apply(input op_t op, input logic [VALUE_W-1:0] value,
                                 input logic [RANK_W-1:0] rank, output kth_result_t res);
    int idx;
    int blk;
    idx = int'(value) % NUM_VALUES;
    blk = idx / BLOCK_SIZE;
    res.sel = '0;
    res.status = STATUS_OK;
    case (op)
      OP_INSERT: begin
        if (hist_count[idx] == COUNT_MAX) begin
          res.status = STATUS_SATURATED;
        end else begin
          hist_count[idx]++;
          blk_total[blk]++;
          stored_total++;
        end
      end
      OP_REMOVE: begin
        if (hist_count[idx] == '0) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          hist_count[idx]--;
          blk_total[blk]--;
          stored_total--;
        end
      end
      OP_QUERY: begin
        if (rank == '0 || 26'(rank) > stored_total) begin
          res.status = STATUS_RANK;
        end else begin
          res.sel = locate_rank(rank);
        end
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until the transfer, then record what it should answer.
  task automatic send_item(input op_t op, input logic [VALUE_W-1:0] value,
                           input logic [RANK_W-1:0] rank, input int gap,
                           input bit typed, input kth_result_t typed_res);
    kth_result_t want;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, rank, value};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    histogram_apply(op, value, rank, want);
    answers_due.push_back(typed ? typed_res : want);
  endtask

  task automatic wait_for_answers();
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Random item: values clustered on a few spots so that removes and queries
  // hit stored entries, with a quarter spread over the whole field.
  task automatic random_item(output op_t op, output logic [VALUE_W-1:0] value,
                             output logic [RANK_W-1:0] rank);
    int r;
    int sel;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      value = VALUE_W'($urandom_range(0, NUM_VALUES - 1));
    end else begin
      value = VALUE_W'(($urandom_range(0, 7) * 131) % NUM_VALUES + $urandom_range(0, 2));
    end
    rank = RANK_W'($urandom_range(0, 65535));
    if (r < 45) begin
      op = OP_INSERT;
    end else if (r < 68) begin
      op = OP_REMOVE;
    end else if (r < 97) begin
      op = OP_QUERY;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        rank = '0;
      end else if (sel == 2) begin
        rank = (stored_total >= 65535) ? 16'hFFFF : RANK_W'(stored_total + 1);
      end else if (sel > 2) begin
        rank = RANK_W'($urandom_range(1, (stored_total == 0) ? 1 :
                                          ((stored_total > 65535) ? 65535 : stored_total)));
      end
    end else begin
      op = OP_UNUSED;
    end
  endtask

  // Result side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    kth_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = answers_due.pop_front();
        if (m_tdata[9:0] != want.sel) begin
          report_mismatch("selected_value", int'(m_tdata[9:0]), int'(want.sel));
        end
        if (m_tdata[11:10] != want.status) begin
          report_mismatch("status", int'(m_tdata[11:10]), int'(want.status));
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold-off so the block backs up into
  // its input.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && answers_seen >= 120) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;

    foreach (hist_count[i]) hist_count[i] = '0;
    foreach (blk_total[i]) blk_total[i] = '0;
    stored_total = '0;

    directed_rows = '{
      // Empty store: every query is out of range, every remove underflows.
      '{OP_QUERY,  10'd0,    16'd1,     1'b1, '{10'd0,    STATUS_RANK}},
      '{OP_QUERY,  10'd1023, 16'd0,     1'b1, '{10'd0,    STATUS_RANK}},
      '{OP_REMOVE, 10'd0,    16'hFFFF,  1'b1, '{10'd0,    STATUS_UNDERFLOW}},
      '{OP_REMOVE, 10'd1023, 16'd0,     1'b1, '{10'd0,    STATUS_UNDERFLOW}},
      '{OP_UNUSED, 10'd1023, 16'hFFFF,  1'b1, '{10'd0,    STATUS_OK}},
      // Both ends of the value range.
      '{OP_INSERT, 10'd0,    16'd0,     1'b1, '{10'd0,    STATUS_OK}},
      '{OP_INSERT, 10'd1023, 16'd0,     1'b1, '{10'd0,    STATUS_OK}},
      '{OP_INSERT, 10'd1023, 16'hFFFF,  1'b1, '{10'd0,    STATUS_OK}},
      '{OP_QUERY,  10'd0,    16'd1,     1'b1, '{10'd0,    STATUS_OK}},
      '{OP_QUERY,  10'd0,    16'd2,     1'b1, '{10'd1023, STATUS_OK}},
      '{OP_QUERY,  10'd0,    16'd3,     1'b1, '{10'd1023, STATUS_OK}},
      '{OP_QUERY,  10'd0,    16'd4,     1'b1, '{10'd0,    STATUS_RANK}},
      '{OP_QUERY,  10'd0,    16'd0,     1'b1, '{10'd0,    STATUS_RANK}},
      '{OP_QUERY,  10'd1023, 16'hFFFF,  1'b1, '{10'd0,    STATUS_RANK}},
      // Values on either side of a block boundary.
      '{OP_INSERT, 10'd31,   16'd0,     1'b0, FROM_MODEL},
      '{OP_INSERT, 10'd32,   16'd0,     1'b0, FROM_MODEL},
      '{OP_INSERT, 10'd31,   16'd0,     1'b0, FROM_MODEL},
      '{OP_QUERY,  10'd0,    16'd3,     1'b0, FROM_MODEL},
      '{OP_QUERY,  10'd0,    16'd4,     1'b0, FROM_MODEL},
      '{OP_REMOVE, 10'd1023, 16'd0,     1'b0, FROM_MODEL},
      '{OP_REMOVE, 10'd1023, 16'd0,     1'b0, FROM_MODEL},
      '{OP_REMOVE, 10'd1023, 16'd0,     1'b1, '{10'd0,    STATUS_UNDERFLOW}},
      '{OP_QUERY,  10'd0,    16'd4,     1'b0, FROM_MODEL},
      '{OP_QUERY,  10'd0,    16'd5,     1'b0, FROM_MODEL},
      '{OP_UNUSED, 10'd0,    16'd0,     1'b0, FROM_MODEL}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].rank,
                pick_gap(), directed_rows[i].typed, directed_rows[i].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Halfway through, let the block run dry before going on.
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        wait_for_answers();
      end
      random_item(op, value, rank);
      send_item(op, value, rank, pick_gap(), 1'b0, FROM_MODEL);
    end
    s_tvalid <= 1'b0;

    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
